>>> design/ultrasonic_range_median_macros.svh
// Assertion macros for the ultrasonic range median block.
// Included by the top level; uses the clock and reset ports by name.
`ifndef ULTRASONIC_RANGE_MEDIAN_MACROS_SVH
`define ULTRASONIC_RANGE_MEDIAN_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define URM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define URM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> design/urm_pkg.sv
// Shared constants and types for the ultrasonic range median block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package urm_pkg;

   localparam int ATTEMPTS   = 5;
   localparam int MEDIAN_IDX = (ATTEMPTS - 1) / 2;
   localparam int IDX_W      = (ATTEMPTS > 1) ? $clog2(ATTEMPTS) : 1;

   localparam int DIST_W = 12;
   localparam int QUOT_W = DIST_W - 1;
   localparam int WB_W   = 20;
   localparam int MW_W   = 16;
   localparam int GAP_W  = 16;
   localparam int TICK_W = 16;

   localparam int TICKS_PER_CM = 58;
   localparam int REM_W        = $clog2(TICKS_PER_CM);

   localparam logic [TICK_W-1:0] TRIG_LOW_TICKS  = TICK_W'(2);
   localparam logic [TICK_W-1:0] TRIG_HIGH_TICKS = TICK_W'(10);

   localparam logic [WB_W-1:0]  WAIT_BUDGET_RESET = WB_W'(50000);
   localparam logic [MW_W-1:0]  MAX_WIDTH_RESET   = MW_W'(58000);
   localparam logic [GAP_W-1:0] GAP_RESET         = GAP_W'(20000);

   // Register indexes on the configuration port.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_BUDGET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WIDTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP         = 2'd2;
   localparam int CSR_DATA_W = WB_W;

   typedef logic signed [DIST_W-1:0] dist_type;

   typedef struct packed {
      logic [WB_W-1:0]  wait_budget;
      logic [MW_W-1:0]  max_width;
      logic [GAP_W-1:0] gap;
   } cfg_type;

   // One finished attempt, handed to the median store.
   typedef struct packed {
      logic             wr;
      logic [IDX_W-1:0] idx;
      dist_type         value;
   } rec_type;

   typedef struct packed {
      logic trig;
      logic busy;
      logic done;
   } status_type;

endpackage

>>> design/urm_ctrl.sv
// Attempt sequencer: trigger timing, wait budget, echo width and cm quotient.
// Depends on urm_pkg.
`timescale 1ns / 1ps

module urm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                start_req,
   input  logic                echo_level,
   input  urm_pkg::cfg_type    cfg,
   output urm_pkg::status_type status,
   output urm_pkg::rec_type    rec
);
   import urm_pkg::*;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
   localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
   localparam logic [2:0] PH_WAIT_END  = 3'd3;
   localparam logic [2:0] PH_WAIT_RISE = 3'd4;
   localparam logic [2:0] PH_MEASURE   = 3'd5;
   localparam logic [2:0] PH_GAP       = 3'd6;

   logic [2:0]        phase_ff, phase_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in;
   logic [WB_W-1:0]   budget_ff, budget_in;
   logic [MW_W-1:0]   width_ff, width_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   logic              budget_ok;
   logic [TICK_W:0]   ticks_inc;
   logic              finish;
   dist_type          fin_value;

   assign budget_ok = budget_ff < cfg.wait_budget;
   assign ticks_inc = {1'b0, ticks_ff} + 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      ticks_in  = ticks_ff;
      budget_in = budget_ff;
      width_in  = width_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      finish    = 1'b0;
      fin_value = '1;
      status    = '0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               phase_in  = PH_TRIG_LOW;
               ticks_in  = '0;
               budget_in = '0;
               width_in  = '0;
               quot_in   = '0;
               rem_in    = '0;
               idx_in    = '0;
            end
         end
         PH_TRIG_LOW: begin
            ticks_in = ticks_inc[TICK_W-1:0];
            if (ticks_inc >= {1'b0, TRIG_LOW_TICKS}) begin
               phase_in = PH_TRIG_HIGH;
               ticks_in = '0;
            end
         end
         PH_TRIG_HIGH: begin
            status.trig = 1'b1;
            ticks_in    = ticks_inc[TICK_W-1:0];
            if (ticks_inc >= {1'b0, TRIG_HIGH_TICKS}) begin
               phase_in  = PH_WAIT_END;
               ticks_in  = '0;
               budget_in = '0;
            end
         end
         PH_WAIT_END: begin
            // A low sample here already counts as the first tick of the rise wait.
            if (!budget_ok) begin
               finish = 1'b1;
            end else begin
               budget_in = budget_ff + 1'b1;
               if (!echo_level) begin
                  phase_in = PH_WAIT_RISE;
               end
            end
         end
         PH_WAIT_RISE: begin
            if (echo_level) begin
               phase_in = PH_MEASURE;
               width_in = '0;
               quot_in  = '0;
               rem_in   = '0;
            end else if (!budget_ok) begin
               finish = 1'b1;
            end else begin
               budget_in = budget_ff + 1'b1;
            end
         end
         PH_MEASURE: begin
            if (!echo_level) begin
               finish    = 1'b1;
               fin_value = dist_type'({1'b0, quot_ff});
            end else if (!budget_ok || width_ff >= cfg.max_width) begin
               finish = 1'b1;
            end else begin
               // Quotient and remainder by the cm constant track the width.
               budget_in = budget_ff + 1'b1;
               width_in  = width_ff + 1'b1;
               if (rem_ff == REM_W'(TICKS_PER_CM - 1)) begin
                  rem_in  = '0;
                  quot_in = quot_ff + 1'b1;
               end else begin
                  rem_in = rem_ff + 1'b1;
               end
            end
         end
         PH_GAP: begin
            ticks_in = ticks_inc[TICK_W-1:0];
            if (ticks_inc >= {1'b0, cfg.gap}) begin
               phase_in = PH_TRIG_LOW;
               ticks_in = '0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (finish) begin
         budget_in = '0;
         width_in  = '0;
         quot_in   = '0;
         rem_in    = '0;
         ticks_in  = '0;
         if (idx_ff == IDX_W'(ATTEMPTS - 1)) begin
            phase_in    = PH_IDLE;
            idx_in      = '0;
            status.done = 1'b1;
         end else begin
            idx_in   = idx_ff + 1'b1;
            phase_in = (cfg.gap == '0) ? PH_TRIG_LOW : PH_GAP;
         end
      end

      status.busy = (phase_in != PH_IDLE);
   end

   assign rec.wr    = finish;
   assign rec.idx   = idx_ff;
   assign rec.value = fin_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         ticks_ff  <= '0;
         budget_ff <= '0;
         width_ff  <= '0;
         quot_ff   <= '0;
         rem_ff    <= '0;
         idx_ff    <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         ticks_ff  <= ticks_in;
         budget_ff <= budget_in;
         width_ff  <= width_in;
         quot_ff   <= quot_in;
         rem_ff    <= rem_in;
         idx_ff    <= idx_in;
      end
   end

endmodule

>>> design/urm_sort.sv
// Sorted reading store: each reading is inserted in order as it arrives,
// so the median is one fixed entry after the last insert. Depends on urm_pkg.
`timescale 1ns / 1ps

module urm_sort (
   input  logic              clock,
   input  logic              step,
   input  urm_pkg::rec_type  rec,
   output urm_pkg::dist_type median
);
   import urm_pkg::*;

   dist_type sorted_ff [ATTEMPTS];
   dist_type sorted_in [ATTEMPTS];
   logic     above     [ATTEMPTS];

   // Entries at or past the fill index count as larger than anything.
   for (genvar p = 0; p < ATTEMPTS; p++) begin : g_ins
      assign above[p] = (IDX_W'(p) >= rec.idx) || (sorted_ff[p] > rec.value);
      if (p == 0) begin : g_first
         assign sorted_in[p] = above[p] ? rec.value : sorted_ff[p];
      end else begin : g_rest
         assign sorted_in[p] = !above[p]     ? sorted_ff[p] :
                               !above[p - 1] ? rec.value    : sorted_ff[p - 1];
      end
   end

   assign median = sorted_in[MEDIAN_IDX];

   always_ff @(posedge clock) begin
      if (step && rec.wr) begin
         sorted_ff <= sorted_in;
      end
   end

endmodule

>>> design/ultrasonic_range_median.sv
// Top level of the ultrasonic range median block: input and result registers,
// configuration registers, handshakes. Depends on urm_pkg, urm_ctrl, urm_sort.
//
//   Channel  Ports    Direction  Carries
//   request  req_*    in         one tick: start_req, echo_level
//   response rsp_*    out        one tick: trigger, busy, done, distance
//   config   csr_*    in         register writes, no read-back
//
// Each accepted tick yields one result; a new tick is taken every cycle while the
// result register is not stalled. A tick passes the input register, then the
// sequencer and the sorted-insert logic feeding the result register.
// Reset is synchronous and returns the sequencer to idle with default registers.
// A stalled result register holds the input register, which then drops req_ready.
`timescale 1ns / 1ps

module ultrasonic_range_median (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_start_req,
   input  logic                                req_echo_level,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_trigger_level,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic signed [urm_pkg::DIST_W-1:0]   rsp_distance_cm,
   input  logic                                csr_wr_en,
   input  logic [urm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [urm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import urm_pkg::*;

`include "ultrasonic_range_median_macros.svh"

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic       in_start_ff;
   logic       in_echo_ff;
   logic       out_valid_ff;
   status_type out_status_ff;
   dist_type   out_dist_ff;

   logic       step;
   logic       req_xfer;
   status_type status;
   rec_type    rec;
   dist_type   median;

   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign req_xfer  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wait_budget <= WAIT_BUDGET_RESET;
         cfg_ff.max_width   <= MAX_WIDTH_RESET;
         cfg_ff.gap         <= GAP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WAIT_BUDGET: cfg_ff.wait_budget <= csr_wdata[WB_W-1:0];
            CSR_MAX_WIDTH:   cfg_ff.max_width   <= csr_wdata[MW_W-1:0];
            CSR_GAP:         cfg_ff.gap         <= csr_wdata[GAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_start_ff <= req_start_req;
         in_echo_ff  <= req_echo_level;
      end
      if (step) begin
         out_status_ff <= status;
         out_dist_ff   <= status.done ? median : dist_type'(0);
      end
   end

   urm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .start_req  (in_start_ff),
      .echo_level (in_echo_ff),
      .cfg        (cfg_ff),
      .status     (status),
      .rec        (rec)
   );

   urm_sort u_sort (
      .clock  (clock),
      .step   (step),
      .rec    (rec),
      .median (median)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_trigger_level = out_status_ff.trig;
   assign rsp_busy_res      = out_status_ff.busy;
   assign rsp_done_res      = out_status_ff.done;
   assign rsp_distance_cm   = out_dist_ff;

   // The sequencer goes idle on the tick that reports the median.
   `URM_ASSERT(a_done_not_busy, out_valid_ff && out_status_ff.done |-> !out_status_ff.busy, "done while busy")
   // A distance is only carried on the done tick.
   `URM_ASSERT(a_dist_only_done, out_valid_ff && !out_status_ff.done |-> out_dist_ff == dist_type'(0), "distance without done")
   // The trigger is driven only within a running sequence.
   `URM_ASSERT(a_trig_in_seq, out_valid_ff && out_status_ff.trig |-> out_status_ff.busy, "trigger while idle")
   // A held input item is not consumed while the result register is full.
   `URM_ASSERT(a_stall_holds, in_valid_ff && out_valid_ff && !rsp_ready |=> in_valid_ff && $stable(in_echo_ff) && $stable(in_start_ff), "input item lost in stall")
   // Nothing is in flight right after reset.
   `URM_ASSERT_ALWAYS(a_reset_empty, reset |=> !in_valid_ff && !out_valid_ff, "pipeline not empty after reset")

endmodule
